[rtl/core/rsp_pkg.sv]
// Package for the road segment proximity test: sizes, payload structs,
// command codes and the segment record. Used by every module of the block.
// No dependencies.
package rsp_pkg;

    localparam int MAX_SEGMENTS  = 256;
    localparam int COORD_BITS    = 20;
    localparam int NEAR_BITS     = 19;
    localparam int IDX_BITS      = $clog2(MAX_SEGMENTS);
    localparam int CNT_BITS      = $clog2(MAX_SEGMENTS + 1);
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS     = 2 * DIFF_BITS;
    localparam int SUM_BITS      = PROD_BITS + 1;
    localparam int SQ_BITS       = 2 * NEAR_BITS;
    localparam int CROSS_SQ_BITS = 2 * PROD_BITS;
    localparam int TL_BITS       = SQ_BITS + PROD_BITS;

    localparam logic [NEAR_BITS-1:0] NEAR_RESET = NEAR_BITS'(300);

    typedef struct packed {
        logic                         command;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic                         new_road;
    } t_in;

    typedef struct packed {
        logic on_road;
        logic status;
    } t_out;

    // Classified operation handed from the front to the back
    typedef enum logic [1:0] {
        OP_QUERY,
        OP_START,
        OP_CHAIN
    } t_op;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    typedef struct packed {
        t_op    op;
        t_point pt;
    } t_item;

    typedef struct packed {
        t_point a;
        t_point b;
    } t_seg;

endpackage

[rtl/core/road_segment_proximity_test.sv]
// Road segment proximity test. Waypoint transfers build a table of up to
// MAX_SEGMENTS segments; query transfers report whether the point lies strictly
// within near_distance of any stored segment. A waypoint is handled in the
// back end as soon as it is popped. For a query, the table's single read port
// streams one segment per cycle into a seven-stage distance pipeline, which is
// then drained. A two-entry queue sits between the front and back ends. The
// table needs no clearing after reset.
module road_segment_proximity_test
    import rsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [NEAR_BITS-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out
);

    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    rsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_item   (q_item)
    );

    rsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_item    (q_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

[rtl/core/rsp_front.sv]
// Front end: accepts input transfers, classifies them and queues them.
// Depends on rsp_pkg.
module rsp_front
    import rsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_in   i_in,
    output logic  o_q_valid,
    input  logic  i_q_pop,
    output t_item o_q_item
);

    t_item      r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       r_lwv;
    t_item      n_item;
    logic       accept;

    assign o_in_ready = (r_fill != 2'd2);
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_fill != 2'd0);
    assign o_q_item   = r_q[r_rd_ptr];

    // Classify: a waypoint chains only after an earlier waypoint of the same road
    always_comb begin
        n_item.pt.x = i_in.coord_x;
        n_item.pt.y = i_in.coord_y;
        if (i_in.command) begin
            n_item.op = OP_QUERY;
        end else if (r_lwv && !i_in.new_road) begin
            n_item.op = OP_CHAIN;
        end else begin
            n_item.op = OP_START;
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

    // Queue pointers and waypoint tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
            r_lwv    <= 1'b0;
        end else begin
            if (accept) begin
                r_wr_ptr <= !r_wr_ptr;
                if (!i_in.command) begin
                    r_lwv <= 1'b1;
                end
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_fill <= r_fill + {1'b0, accept} - {1'b0, i_q_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3) else $error("queue fill out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd0 || r_fill == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill");
`endif

endmodule

[rtl/core/rsp_dist.sv]
// Pipelined point-to-segment distance test, one segment per cycle, seven stages.
// Depends on rsp_pkg.
module rsp_dist
    import rsp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_seg               i_seg,
    input  t_point             i_pt,
    input  logic [SQ_BITS-1:0] i_tsq,
    output logic               o_hit_valid,
    output logic               o_hit,
    output logic               o_busy
);

    localparam int HALF_N = NEAR_BITS;
    localparam int HALF_D = DIFF_BITS;

    logic [6:0] r_v;

    // stage 1: differences
    logic signed [DIFF_BITS-1:0] r1_dx, r1_dy, r1_ex, r1_ey, r1_fx, r1_fy;
    // stage 2: products
    logic signed [PROD_BITS-1:0] r2_dxdx, r2_dydy, r2_exdx, r2_eydy;
    logic signed [PROD_BITS-1:0] r2_exdy, r2_eydx, r2_exex, r2_eyey, r2_fxfx, r2_fyfy;
    // stage 3: sums
    logic signed [SUM_BITS-1:0] r3_len, r3_dot, r3_cross;
    logic [SUM_BITS-1:0]        r3_da, r3_db;
    // stage 4: case flags and magnitude
    logic                 r4_use_a, r4_use_b, r4_near_a, r4_near_b;
    logic [PROD_BITS-1:0] r4_mag, r4_len;
    logic signed [SUM_BITS-1:0] n4_neg;
    // stage 5: partial products
    logic                 r5_use_a, r5_use_b, r5_near_a, r5_near_b;
    logic [PROD_BITS-1:0] r5_hh, r5_hl, r5_ll;
    logic [HALF_N+HALF_D-1:0] r5_t_hh, r5_t_hl, r5_t_lh, r5_t_ll;
    // stage 6: full cross square and threshold-length product
    logic                     r6_use_a, r6_use_b, r6_near_a, r6_near_b;
    logic [CROSS_SQ_BITS-1:0] r6_csq;
    logic [TL_BITS-1:0]       r6_tl;
    // stage 7: result
    logic r7_hit;

    assign n4_neg      = -r3_cross;
    assign o_hit_valid = r_v[6];
    assign o_hit       = r7_hit;
    assign o_busy      = |r_v;

    // Advance the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        r1_dx <= DIFF_BITS'(i_seg.b.x) - DIFF_BITS'(i_seg.a.x);
        r1_dy <= DIFF_BITS'(i_seg.b.y) - DIFF_BITS'(i_seg.a.y);
        r1_ex <= DIFF_BITS'(i_pt.x) - DIFF_BITS'(i_seg.a.x);
        r1_ey <= DIFF_BITS'(i_pt.y) - DIFF_BITS'(i_seg.a.y);
        r1_fx <= DIFF_BITS'(i_pt.x) - DIFF_BITS'(i_seg.b.x);
        r1_fy <= DIFF_BITS'(i_pt.y) - DIFF_BITS'(i_seg.b.y);

        r2_dxdx <= r1_dx * r1_dx;
        r2_dydy <= r1_dy * r1_dy;
        r2_exdx <= r1_ex * r1_dx;
        r2_eydy <= r1_ey * r1_dy;
        r2_exdy <= r1_ex * r1_dy;
        r2_eydx <= r1_ey * r1_dx;
        r2_exex <= r1_ex * r1_ex;
        r2_eyey <= r1_ey * r1_ey;
        r2_fxfx <= r1_fx * r1_fx;
        r2_fyfy <= r1_fy * r1_fy;

        r3_len   <= SUM_BITS'(r2_dxdx) + SUM_BITS'(r2_dydy);
        r3_dot   <= SUM_BITS'(r2_exdx) + SUM_BITS'(r2_eydy);
        r3_cross <= SUM_BITS'(r2_exdy) - SUM_BITS'(r2_eydx);
        r3_da    <= SUM_BITS'($unsigned(r2_exex)) + SUM_BITS'($unsigned(r2_eyey));
        r3_db    <= SUM_BITS'($unsigned(r2_fxfx)) + SUM_BITS'($unsigned(r2_fyfy));

        r4_use_a  <= (r3_len == '0) || (r3_dot <= 0);
        r4_use_b  <= (r3_dot >= r3_len);
        r4_near_a <= (r3_da < SUM_BITS'(i_tsq));
        r4_near_b <= (r3_db < SUM_BITS'(i_tsq));
        r4_mag    <= r3_cross[SUM_BITS-1] ? n4_neg[PROD_BITS-1:0]
                                          : r3_cross[PROD_BITS-1:0];
        r4_len    <= r3_len[PROD_BITS-1:0];

        r5_use_a  <= r4_use_a;
        r5_use_b  <= r4_use_b;
        r5_near_a <= r4_near_a;
        r5_near_b <= r4_near_b;
        r5_hh <= r4_mag[PROD_BITS-1:HALF_D] * r4_mag[PROD_BITS-1:HALF_D];
        r5_hl <= r4_mag[PROD_BITS-1:HALF_D] * r4_mag[HALF_D-1:0];
        r5_ll <= r4_mag[HALF_D-1:0] * r4_mag[HALF_D-1:0];
        r5_t_hh <= i_tsq[SQ_BITS-1:HALF_N] * r4_len[PROD_BITS-1:HALF_D];
        r5_t_hl <= i_tsq[SQ_BITS-1:HALF_N] * r4_len[HALF_D-1:0];
        r5_t_lh <= i_tsq[HALF_N-1:0] * r4_len[PROD_BITS-1:HALF_D];
        r5_t_ll <= i_tsq[HALF_N-1:0] * r4_len[HALF_D-1:0];

        r6_use_a  <= r5_use_a;
        r6_use_b  <= r5_use_b;
        r6_near_a <= r5_near_a;
        r6_near_b <= r5_near_b;
        r6_csq <= (CROSS_SQ_BITS'(r5_hh) << (2 * HALF_D))
                + (CROSS_SQ_BITS'(r5_hl) << (HALF_D + 1))
                + CROSS_SQ_BITS'(r5_ll);
        r6_tl  <= (TL_BITS'(r5_t_hh) << (HALF_N + HALF_D))
                + (TL_BITS'(r5_t_hl) << HALF_N)
                + (TL_BITS'(r5_t_lh) << HALF_D)
                + TL_BITS'(r5_t_ll);

        // Pick the end point test or the interior test
        if (r6_use_a) begin
            r7_hit <= r6_near_a;
        end else if (r6_use_b) begin
            r7_hit <= r6_near_b;
        end else begin
            r7_hit <= (r6_csq < r6_tl);
        end
    end

endmodule

[rtl/core/rsp_back.sv]
// Back end: segment table, waypoint chaining, query sequencer and result register.
// Depends on rsp_pkg and rsp_dist.
module rsp_back
    import rsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [NEAR_BITS-1:0] i_cfg_data,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  t_item                i_q_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } t_state;

    t_state               r_state;
    logic [NEAR_BITS-1:0] r_near;
    logic [SQ_BITS-1:0]   r_tsq;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  r_k;
    t_point               r_last;
    t_point               r_pt;
    logic                 r_any;
    logic                 r_rd_valid;
    t_seg                 r_rd;
    t_seg                 r_mem [MAX_SEGMENTS];
    logic                 r_out_valid;
    t_out                 r_out;

    logic out_free;
    logic wr_en;
    logic issue;
    logic hit_valid;
    logic hit;
    logic dist_busy;
    t_seg wr_seg;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid
                         && ((i_q_item.op == OP_QUERY) || out_free);
    assign wr_en       = o_q_pop && (i_q_item.op == OP_CHAIN)
                         && (r_count < CNT_BITS'(MAX_SEGMENTS));
    assign issue       = (r_state == S_ISSUE) && (r_k < r_count);
    assign wr_seg.a    = r_last;
    assign wr_seg.b    = i_q_item.pt;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Segment table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_BITS-1:0]] <= wr_seg;
        end
        r_rd <= r_mem[r_k[IDX_BITS-1:0]];
    end

    // Threshold register and its square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RESET;
        end else if (i_cfg_we) begin
            r_near <= i_cfg_data;
        end
        r_tsq <= r_near * r_near;
    end

    // Sequencer, table fill and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_last      <= '0;
            r_any       <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_valid <= issue;
            if (hit_valid && hit) begin
                r_any <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_item.op == OP_QUERY) begin
                            r_pt    <= i_q_item.pt;
                            r_k     <= '0;
                            r_any   <= 1'b0;
                            r_state <= S_ISSUE;
                        end else begin
                            r_last        <= i_q_item.pt;
                            r_out_valid   <= 1'b1;
                            r_out.on_road <= 1'b0;
                            r_out.status  <= (i_q_item.op == OP_CHAIN) && !wr_en;
                            if (wr_en) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                    end
                end
                S_ISSUE: begin
                    if (issue) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    // Drain the pipeline, then hand over the verdict
                    if (!r_rd_valid && !dist_busy && out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out.on_road <= r_any;
                        r_out.status  <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    rsp_dist u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_rd_valid),
        .i_seg       (r_rd),
        .i_pt        (r_pt),
        .i_tsq       (r_tsq),
        .o_hit_valid (hit_valid),
        .o_hit       (hit),
        .o_busy      (dist_busy)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_SEGMENTS)) else $error("segment count overflow");
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_k <= r_count)) else $error("issue index past count");
    a_hit_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit_valid |-> (r_state == S_ISSUE || r_state == S_WAIT))
        else $error("distance result outside a query");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != S_IDLE || r_out_valid))
        else $error("popped item left no trace");
`endif

endmodule

[tb/sv/rsp_checker.sv]
// Checker for the road segment proximity test: watches both transfer channels,
// keeps its own copy of the segment table and threshold, and compares results.
// Depends on rsp_pkg.
`timescale 1ns / 100ps

module rsp_checker
    import rsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [NEAR_BITS-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in                  i_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out                 i_out,
    output int                   o_errors,
    output int                   o_pending
);

    t_point           seg_a [MAX_SEGMENTS];
    t_point           seg_b [MAX_SEGMENTS];
    int               seg_total;
    t_point           prev_pt;
    logic             prev_ok;
    logic [NEAR_BITS-1:0] thresh;
    t_out             awaited [$];

    // Exact squared distance test against one stored segment
    function automatic logic seg_is_near(t_point a, t_point b, t_point p,
                                         logic [NEAR_BITS-1:0] t);
        longint dx, dy, ex, ey, len, dot, crs, fx, fy;
        logic [127:0] csq, tl;
        logic [127:0] tsq;
        dx = longint'(b.x) - longint'(a.x);
        dy = longint'(b.y) - longint'(a.y);
        ex = longint'(p.x) - longint'(a.x);
        ey = longint'(p.y) - longint'(a.y);
        len = dx * dx + dy * dy;
        dot = ex * dx + ey * dy;
        crs = ex * dy - ey * dx;
        tsq = 128'(t) * 128'(t);
        if (len == 0 || dot <= 0)
            return 128'(ex * ex + ey * ey) < tsq;
        if (dot >= len) begin
            fx = longint'(p.x) - longint'(b.x);
            fy = longint'(p.y) - longint'(b.y);
            return 128'(fx * fx + fy * fy) < tsq;
        end
        if (crs < 0) crs = -crs;
        csq = 128'(crs) * 128'(crs);
        tl  = tsq * 128'(len);
        return csq < tl;
    endfunction

    // Predict on every input transfer, compare on every output transfer
    always @(posedge i_clk) begin
        t_out   pred;
        t_point p;
        t_out   want;
        int     errs;
        if (!i_rst_n) begin
            seg_total <= 0;
            prev_ok   <= 1'b0;
            prev_pt   <= '0;
            thresh    <= NEAR_RESET;
            o_errors  <= 0;
            o_pending <= 0;
            awaited.delete();
        end else begin
            errs = 0;
            if (i_cfg_we) thresh <= i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                pred = '0;
                p.x = i_in.coord_x;
                p.y = i_in.coord_y;
                if (i_in.command) begin
                    for (int k = 0; k < seg_total; k++)
                        if (seg_is_near(seg_a[k], seg_b[k], p, thresh)) pred.on_road = 1'b1;
                end else begin
                    if (prev_ok && !i_in.new_road) begin
                        if (seg_total < MAX_SEGMENTS) begin
                            seg_a[seg_total] = prev_pt;
                            seg_b[seg_total] = p;
                            seg_total <= seg_total + 1;
                        end else begin
                            pred.status = 1'b1;
                        end
                    end
                    prev_pt <= p;
                    prev_ok <= 1'b1;
                end
                awaited.push_back(pred);
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    $error("result with nothing awaited");
                    errs = errs + 1;
                end else begin
                    want = awaited.pop_front();
                    if (want.on_road !== i_out.on_road) begin
                        $error("on_road: expected %0b, got %0b", want.on_road, i_out.on_road);
                        errs = errs + 1;
                    end
                    if (want.status !== i_out.status) begin
                        $error("status: expected %0b, got %0b", want.status, i_out.status);
                        errs = errs + 1;
                    end
                end
            end
            o_errors  <= o_errors + errs;
            o_pending <= awaited.size();
        end
    end

endmodule

[tb/sv/tb_road_segment_proximity_test.sv]
// Testbench top for the road segment proximity test: clock, reset, stimulus
// and verdict. Depends on rsp_pkg, rsp_checker and the block itself.
`timescale 1ns / 100ps

module tb_road_segment_proximity_test;
    import rsp_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [NEAR_BITS-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in                  i_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out                 o_out;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles;
    logic                 calm;

    road_segment_proximity_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    rsp_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out(o_out),
        .o_errors(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver back-pressure: random stall bursts, none near the end
    initial begin
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 3);
                i_out_ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb_road_segment_proximity_test: done, errors");
            $finish;
        end
    end

    // Present one item and hold it until the transfer; valid stays high for a
    // following item and drops only on a gap or a drain
    task automatic send_item(logic cmd, int x, int y, logic nr);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_in.command     <= cmd;
        i_in.coord_x     <= COORD_BITS'(x);
        i_in.coord_y     <= COORD_BITS'(y);
        i_in.new_road    <= nr;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drain all results, then let the block settle before touching config
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_near(logic [NEAR_BITS-1:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int rnd_coord(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random traffic around a local centre, mostly roads and nearby queries
    task automatic random_phase(int count, int span);
        int cx, cy, x, y;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                cx = rnd_coord(524287 - span);
                cy = rnd_coord(524287 - span);
            end
            case ($urandom_range(0, 9))
                0: send_item(1'($urandom), int'($urandom), int'($urandom), 1'($urandom));
                1, 2, 3, 4: begin
                    x = cx + rnd_coord(span);
                    y = cy + rnd_coord(span);
                    send_item(1'b0, x, y, $urandom_range(0, 7) == 0);
                end
                default: begin
                    x = cx + rnd_coord(span);
                    y = cy + rnd_coord(span);
                    send_item(1'b1, x, y, 1'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        calm        = 1'b0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, first waypoint, new road, extremes
        send_item(1'b1, 0, 0, 1'b0);
        send_item(1'b0, 0, 0, 1'b0);
        send_item(1'b0, 1000, 0, 1'b0);
        send_item(1'b1, 500, 299, 1'b0);
        send_item(1'b1, 500, 300, 1'b1);
        send_item(1'b1, -299, 0, 1'b0);
        send_item(1'b1, 1299, 0, 1'b0);
        send_item(1'b0, 1000, 0, 1'b0);
        send_item(1'b1, 1000, 200, 1'b0);
        send_item(1'b0, -524288, -524288, 1'b1);
        send_item(1'b0, 524287, 524287, 1'b0);
        send_item(1'b1, 524287, -524288, 1'b0);
        send_item(1'b1, -524288, 524287, 1'b1);
        send_item(1'b1, 0, 0, 1'b0);
        write_near('0);
        send_item(1'b1, 1000, 0, 1'b0);
        write_near({NEAR_BITS{1'b1}});
        send_item(1'b1, -524288, 524287, 1'b0);
        send_item(1'b1, 524287, -524288, 1'b0);
        write_near(NEAR_BITS'(300));

        // Random phases with a range of thresholds
        random_phase(250, 2000);
        write_near(NEAR_BITS'($urandom_range(1, 2000)));
        random_phase(250, 5000);
        write_near(NEAR_BITS'($urandom));
        random_phase(200, 524287 / 2);
        write_near(NEAR_BITS'(1));

        // Fill the table so further segments drop
        for (int i = 0; i < 260; i++)
            send_item(1'b0, rnd_coord(3000), rnd_coord(3000), $urandom_range(0, 15) == 0);
        write_near(NEAR_BITS'($urandom_range(0, 4000)));
        random_phase(150, 3000);
        write_near({NEAR_BITS{1'b1}});
        random_phase(100, 524287 / 2);

        // Last stretch without idling
        calm = 1'b1;
        write_near(NEAR_BITS'($urandom_range(100, 3000)));
        random_phase(150, 3000);

        wait_drained();
        if (fail_count == 0)
            $display("tb_road_segment_proximity_test: done, clean");
        else
            $display("tb_road_segment_proximity_test: done, errors");
        $finish;
    end

endmodule
